/* design/lpwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwm_pkg
// Shared types and constants for the multi-channel LED PWM unit.
// ----------------------------------------------------------------------------
package lpwm_pkg;

    localparam int LED_W    = 3;
    localparam int BRIGHT_W = 8;
    localparam int MASK_W   = 8;

    localparam int CHANNELS_DEF  = 8;
    localparam int STEPS_DEF     = 16;
    localparam int LED_COUNT_DEF = 8;

    // register indexes (paddr bit 2)
    localparam logic REG_REGISTERED = 1'b0;
    localparam logic REG_POLARITY   = 1'b1;

    // input kinds carried on s_tuser
    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        CMD_FREE,
        CMD_SET,
        CMD_TICK
    } cmd_kind_t;

    // token that walks down the cell chain
    typedef struct packed {
        logic             valid;
        cmd_kind_t        kind;
        logic [LED_W-1:0] led;
        logic             claim;   // still looking for a free channel
    } cmd_t;

    typedef struct packed {
        logic             active;
        logic             held;    // channel belongs to the probed LED
        logic             emit;
        logic [LED_W-1:0] led;     // zero unless emit
        logic             lit;     // zero unless emit
    } cell_stat_t;

    typedef struct packed {
        logic             write;
        logic             flush;
        logic [LED_W-1:0] led;
        logic             lit;
    } pend_req_t;

    typedef struct packed {
        logic pend_valid;
        logic slot_free;
    } out_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

endpackage

/* design/multi_channel_led_pwm_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_led_pwm_unit
// Pool of PWM channels shared by LEDs, built as a chain of channel cells.
// ----------------------------------------------------------------------------
//  channel   | ports          | transaction
//  ----------+----------------+--------------------------------------------
//  input     | s_t*           | tuser = action, tdata = led, brightness
//  result    | m_t*           | tdata = led, lit, pin level; tlast = final
//  config    | APB p*         | 0x0 registered mask, 0x4 polarity mask
//
//  An accepted set or tick that acts on the pool sends a token down the
//  chain, one cell per cycle unless the chain is frozen: accept, chain walk, flush.
//  Items that cause nothing send no token. A stalled result port freezes
//  the chain when a cell has a pin change while a staged write cannot move
//  out, and holds the flush state. Reset is synchronous; the channel slots
//  clear at once, no clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_led_pwm_unit
    import lpwm_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int STEPS     = STEPS_DEF,
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [2:0] led_number, [10:3] brightness
    input  logic        s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [2:0] target_led, [3] lit, [4] pin_level
    output logic        m_tlast,    // final_write
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LVL_W = $clog2(STEPS);

    state_t            state_reg, state_next;
    logic [MASK_W-1:0] registered_reg, registered_next;
    logic [MASK_W-1:0] polarity_reg, polarity_next;
    logic [LVL_W-1:0]  counter_reg, counter_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    logic               accept;
    logic               launch;
    logic               adv;
    logic               s_action;
    logic [LED_W-1:0]   s_led;
    logic [BRIGHT_W-1:0] s_bright;
    logic               led_ok;
    logic               forced;
    logic               go_free;
    logic               go_set;
    logic               go_tick;
    logic               held_any;
    logic               any_active;
    logic               emit_any;
    logic [LED_W-1:0]   emit_led;
    logic               emit_lit;
    logic               sweep_end;
    logic               flush_req;
    logic               cfg_wr;
    cmd_t               launch_cmd;
    pend_req_t          pend_req;
    out_stat_t          out_stat;

    cmd_t               cmd_vec   [CHANNELS];
    cell_stat_t         stat_vec  [CHANNELS];
    logic [CHANNELS-1:0] tok_vec;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        registered_next = registered_reg;
        polarity_next   = polarity_reg;
        if (cfg_wr) begin
            case (paddr[2])
                REG_REGISTERED: registered_next = pwdata[MASK_W-1:0];
                REG_POLARITY:   polarity_next   = pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_REGISTERED: prdata = {24'd0, registered_reg};
            REG_POLARITY:   prdata = {24'd0, polarity_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign s_action = s_tuser;
    assign s_led    = s_tdata[2:0];
    assign s_bright = s_tdata[10:3];
    assign led_ok   = int'(s_led) < LED_COUNT;
    assign forced   = (s_bright == '0) || (int'(s_bright) >= STEPS - 1);
    assign accept   = s_tvalid && s_tready;

    assign go_free = (s_action == ACT_SET) && led_ok && forced;
    assign go_set  = (s_action == ACT_SET) && led_ok && !forced && registered_reg[s_led];
    assign go_tick = (s_action == ACT_TICK) && any_active;
    assign launch  = accept && (go_free || go_set || go_tick);

    always_comb begin
        launch_cmd.valid = launch;
        launch_cmd.led   = s_led;
        launch_cmd.claim = go_set && !held_any;
        if (go_tick) begin
            launch_cmd.kind = CMD_TICK;
        end else if (go_set) begin
            launch_cmd.kind = CMD_SET;
        end else begin
            launch_cmd.kind = CMD_FREE;
        end
    end

    always_comb begin
        counter_next = counter_reg;
        level_next   = level_reg;
        if (launch && go_tick) begin
            counter_next = (counter_reg == LVL_W'(STEPS - 1)) ? '0 : counter_reg + 1'b1;
        end
        if (launch && go_set) begin
            level_next = s_bright[LVL_W-1:0];
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        cmd_t cmd_in;
        if (i == 0) begin : g_head
            assign cmd_in = launch_cmd;
        end else begin : g_link
            assign cmd_in = cmd_vec[i-1];
        end

        lpwm_cell #(
            .LVL_W(LVL_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .cmd_i    (cmd_in),
            .cmd_o    (cmd_vec[i]),
            .level_i  (level_reg),
            .counter_i(counter_reg),
            .probe_led(s_led),
            .stat_o   (stat_vec[i])
        );

        assign tok_vec[i] = cmd_vec[i].valid;
    end

    // only the cell holding the token can emit, so the OR picks its data
    always_comb begin
        held_any   = 1'b0;
        any_active = 1'b0;
        emit_any   = 1'b0;
        emit_led   = '0;
        emit_lit   = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            held_any   = held_any | stat_vec[i].held;
            any_active = any_active | stat_vec[i].active;
            emit_any   = emit_any | stat_vec[i].emit;
            emit_led   = emit_led | stat_vec[i].led;
            emit_lit   = emit_lit | stat_vec[i].lit;
        end
    end

    // freeze the chain while a new write cannot displace the pending one
    assign adv       = !(emit_any && out_stat.pend_valid && !out_stat.slot_free);
    assign sweep_end = tok_vec[CHANNELS-1] && adv;

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (launch) state_next = ST_SWEEP;
            ST_SWEEP: if (sweep_end) state_next = ST_FLUSH;
            ST_FLUSH: if (!out_stat.pend_valid || out_stat.slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        flush_req = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SWEEP: ;
            ST_FLUSH: flush_req = 1'b1;
            default:  ;
        endcase
    end

    always_comb begin
        pend_req.flush = flush_req;
        if (s_tready) begin
            pend_req.write = accept && go_free;
            pend_req.led   = s_led;
            pend_req.lit   = s_bright != '0;
        end else begin
            pend_req.write = emit_any && adv;
            pend_req.led   = emit_led;
            pend_req.lit   = emit_lit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            registered_reg <= '0;
            polarity_reg   <= '1;
            counter_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            registered_reg <= registered_next;
            polarity_reg   <= polarity_next;
            counter_reg    <= counter_next;
        end
        level_reg <= level_next;
    end

    // ---------------- result path ----------------
    lpwm_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (pend_req),
        .polarity(polarity_reg),
        .stat_o  (out_stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // ---------------- assertions ----------------
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one token in the cell chain");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (tok_vec == '0) && !emit_any)
        else $error("cell activity while idle");

    a_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(counter_reg) < STEPS)
        else $error("step counter out of range");

    a_flush_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) && (state_next == ST_IDLE) |=> !out_stat.pend_valid)
        else $error("pending write left behind after flush");

endmodule

/* design/lpwm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwm_cell
// One PWM channel slot. Acts on the token it holds and passes it on.
// ----------------------------------------------------------------------------
module lpwm_cell
    import lpwm_pkg::*;
#(
    parameter int LVL_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  cmd_t             cmd_i,
    output cmd_t             cmd_o,
    input  logic [LVL_W-1:0] level_i,
    input  logic [LVL_W-1:0] counter_i,
    input  logic [LED_W-1:0] probe_led,
    output cell_stat_t       stat_o
);

    logic             active_reg, active_next;
    logic [LED_W-1:0] led_reg, led_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pin_reg, pin_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_fwd;
    logic             match;
    logic             on;
    logic             emit;

    assign match = active_reg && (led_reg == cmd_reg.led);
    assign on    = counter_i < level_reg;

    always_comb begin
        active_next = active_reg;
        led_next    = led_reg;
        level_next  = level_reg;
        pin_next    = pin_reg;
        cmd_fwd     = cmd_reg;
        emit        = 1'b0;
        if (cmd_reg.valid) begin
            case (cmd_reg.kind)
                CMD_FREE: begin
                    if (match) begin
                        active_next = 1'b0;
                        led_next    = '0;
                        level_next  = '0;
                        pin_next    = 1'b0;
                    end
                end
                CMD_SET: begin
                    if (match) begin
                        level_next = level_i;
                        pin_next   = 1'b0;
                    end else if (cmd_reg.claim && !active_reg) begin
                        active_next   = 1'b1;
                        led_next      = cmd_reg.led;
                        level_next    = level_i;
                        pin_next      = 1'b0;
                        cmd_fwd.claim = 1'b0;
                    end
                end
                CMD_TICK: begin
                    if (active_reg && (on != pin_reg)) begin
                        pin_next = on;
                        emit     = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            led_reg    <= '0;
            level_reg  <= '0;
            pin_reg    <= 1'b0;
            cmd_reg    <= '0;
        end else if (adv) begin
            active_reg <= active_next;
            led_reg    <= led_next;
            level_reg  <= level_next;
            pin_reg    <= pin_next;
            cmd_reg    <= cmd_i;
        end
    end

    assign cmd_o         = cmd_fwd;
    assign stat_o.active = active_reg;
    assign stat_o.held   = active_reg && (led_reg == probe_led);
    assign stat_o.emit   = emit;
    assign stat_o.led    = emit ? led_reg : '0;
    assign stat_o.lit    = emit & on;

endmodule

/* design/lpwm_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwm_out
// Result staging: one pending write plus the output register. A write is
// released as non-final when the next one arrives, or as final on flush.
// ----------------------------------------------------------------------------
module lpwm_out
    import lpwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pend_req_t         req_i,
    input  logic [MASK_W-1:0] polarity,
    output out_stat_t         stat_o,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [2:0] target_led, [3] lit, [4] pin_level
    output logic              m_tlast    // final_write
);

    logic             pend_valid_reg, pend_valid_next;
    logic [LED_W-1:0] pend_led_reg, pend_led_next;
    logic             pend_lit_reg, pend_lit_next;
    logic             out_valid_reg, out_valid_next;
    logic [LED_W-1:0] out_led_reg, out_led_next;
    logic             out_lit_reg, out_lit_next;
    logic             out_pin_reg, out_pin_next;
    logic             out_last_reg, out_last_next;
    logic             slot_free;
    logic             move;
    logic             flush_go;

    assign slot_free = !out_valid_reg || m_tready;
    // caller only writes when the slot can take the older pending entry
    assign move      = req_i.write && pend_valid_reg;
    assign flush_go  = req_i.flush && pend_valid_reg && slot_free;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_led_next   = pend_led_reg;
        pend_lit_next   = pend_lit_reg;
        out_valid_next  = out_valid_reg;
        out_led_next    = out_led_reg;
        out_lit_next    = out_lit_reg;
        out_pin_next    = out_pin_reg;
        out_last_next   = out_last_reg;

        if (move || flush_go) begin
            out_valid_next = 1'b1;
            out_led_next   = pend_led_reg;
            out_lit_next   = pend_lit_reg;
            out_pin_next   = pend_lit_reg ~^ polarity[pend_led_reg];
            out_last_next  = flush_go;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (req_i.write) begin
            pend_valid_next = 1'b1;
            pend_led_next   = req_i.led;
            pend_lit_next   = req_i.lit;
        end else if (flush_go) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_led_reg <= pend_led_next;
        pend_lit_reg <= pend_lit_next;
        out_led_reg  <= out_led_next;
        out_lit_reg  <= out_lit_next;
        out_pin_reg  <= out_pin_next;
        out_last_reg <= out_last_next;
    end

    assign stat_o.pend_valid = pend_valid_reg;
    assign stat_o.slot_free  = slot_free;
    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {3'b000, out_pin_reg, out_lit_reg, out_led_reg};
    assign m_tlast           = out_last_reg;

endmodule

/* sim/lpwm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpwm_checker
// Watches the input, result and APB channels of the LED PWM unit, keeps its
// own copy of the channel pool, and compares every pin write with the oldest
// predicted one, field by field.
// ----------------------------------------------------------------------------
module lpwm_checker
    import lpwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [2:0] led_number, [10:3] brightness
    input  logic        s_tuser,    // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [2:0] target_led, [3] lit, [4] pin_level
    input  logic        m_tlast,    // final_write
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          writes_pending
);

    localparam int N_CH    = CHANNELS_DEF;
    localparam int N_STEPS = STEPS_DEF;
    localparam int N_LEDS  = LED_COUNT_DEF;
    localparam int CNT_W   = $clog2(N_STEPS);

    typedef struct packed {
        logic [LED_W-1:0] led;
        logic             lit;
        logic             pin;
        logic             last;
    } pin_write_t;

    pin_write_t exp_writes[$];

    logic [MASK_W-1:0]   reg_mask;
    logic [MASK_W-1:0]   pol_mask;
    logic [CNT_W-1:0]    step_cnt;
    logic                ch_active [N_CH];
    logic [LED_W-1:0]    ch_led    [N_CH];
    logic [BRIGHT_W-1:0] ch_level  [N_CH];
    logic                ch_lit    [N_CH];

    pin_write_t got;
    pin_write_t want;

    task automatic report(input string field, input logic [7:0] seen, input logic [7:0] exp_v);
        if (fail_count < 40)
            $display("%0t lpwm_checker: %s is %0h, expected %0h", $time, field, seen, exp_v);
        fail_count++;
    endtask

    function automatic void push_write(input logic [LED_W-1:0] led, input logic lit,
                                       input logic last);
        pin_write_t w;
        logic pol;
        pol    = pol_mask[led];
        w.led  = led;
        w.lit  = lit;
        w.pin  = lit ? pol : ~pol;
        w.last = last;
        exp_writes.push_back(w);
    endfunction

    function automatic void clear_channel(input int i);
        ch_active[i] = 1'b0;
        ch_led[i]    = '0;
        ch_level[i]  = '0;
        ch_lit[i]    = 1'b0;
    endfunction

    // apply one accepted transaction to the pool and queue the pin writes it causes
    function automatic void predict_writes(input logic act, input logic [LED_W-1:0] led,
                                           input logic [BRIGHT_W-1:0] br);
        int  hit;
        int  n_chg;
        int  k;
        logic any;
        logic on;
        if (act == ACT_SET) begin
            if (int'(led) >= N_LEDS)
                return;
            hit = -1;
            for (int i = 0; i < N_CH; i++)
                if (hit < 0 && ch_active[i] && ch_led[i] == led)
                    hit = i;
            // off or fully on: release the channel, drive the pin directly
            if (br == 0 || int'(br) >= N_STEPS - 1) begin
                if (hit >= 0)
                    clear_channel(hit);
                push_write(led, br != 0, 1'b1);
                return;
            end
            if (!reg_mask[led])
                return;
            if (hit < 0) begin
                for (int i = 0; i < N_CH; i++)
                    if (hit < 0 && !ch_active[i])
                        hit = i;
                if (hit < 0)
                    return;
                ch_led[hit] = led;
            end
            ch_level[hit]  = br;
            ch_active[hit] = 1'b1;
            ch_lit[hit]    = 1'b0;
            return;
        end

        any = 1'b0;
        for (int i = 0; i < N_CH; i++)
            if (ch_active[i])
                any = 1'b1;
        if (!any)
            return;
        step_cnt = (int'(step_cnt) == N_STEPS - 1) ? '0 : step_cnt + 1'b1;

        n_chg = 0;
        for (int i = 0; i < N_CH; i++)
            if (ch_active[i] && ((step_cnt < ch_level[i]) != ch_lit[i]))
                n_chg++;
        k = 0;
        for (int i = 0; i < N_CH; i++) begin
            if (ch_active[i]) begin
                on = step_cnt < ch_level[i];
                if (on != ch_lit[i]) begin
                    ch_lit[i] = on;
                    k++;
                    push_write(ch_led[i], on, k == n_chg);
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_mask = '0;
            pol_mask = '1;
            step_cnt = '0;
            for (int i = 0; i < N_CH; i++)
                clear_channel(i);
            exp_writes.delete();
        end else begin
            // results go first: a write at this edge belongs to an earlier transaction
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[2:0], m_tdata[3], m_tdata[4], m_tlast};
                if (exp_writes.size() == 0) begin
                    report("unexpected write, target_led", 8'(got.led), 8'h0);
                end else begin
                    want = exp_writes.pop_front();
                    if (got.led != want.led)
                        report("target_led", 8'(got.led), 8'(want.led));
                    if (got.lit != want.lit)
                        report("lit", 8'(got.lit), 8'(want.lit));
                    if (got.pin != want.pin)
                        report("pin_level", 8'(got.pin), 8'(want.pin));
                    if (got.last != want.last)
                        report("final_write", 8'(got.last), 8'(want.last));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_REGISTERED: reg_mask = pwdata[MASK_W-1:0];
                    REG_POLARITY:   pol_mask = pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_writes(s_tuser, s_tdata[2:0], s_tdata[10:3]);
        end
        writes_pending = exp_writes.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the LED PWM unit with a directed opening and randomized phases of
// set and tick transactions under several mask settings, with bursty input
// and a stalling result port; the checker predicts and compares the writes.
// ----------------------------------------------------------------------------
module tb_top;
    import lpwm_pkg::*;

    localparam int LATENCY = CHANNELS_DEF + 4;
    localparam int LIMIT   = 400000;
    localparam int N_PHASE = 5;
    localparam int PER_PHASE = 64;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int writes_pending;
    int cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    bit tx_calm = 1'b0;
    logic rx_calm = 1'b0;

    always #5 aclk = ~aclk;

    multi_channel_led_pwm_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lpwm_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .writes_pending (writes_pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("multi_channel_led_pwm_unit: mismatch");
            $finish;
        end
    end

    // result port back-pressure: runs of stalls, off while rx_calm
    always @(posedge aclk) begin
        if (rx_calm) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic act, input logic [LED_W-1:0] led,
                             input logic [BRIGHT_W-1:0] br);
        int   gap;
        logic ok;
        if (burst_left == 0) begin
            gap = (tx_calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, br, led};
        ok = 1'b0;
        while (!ok) begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end
        burst_left--;
    endtask

    // hold input until every predicted write has come out, then let the chain settle
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (writes_pending != 0)
            @(negedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [MASK_W-1:0] val);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic                act;
        logic [LED_W-1:0]    led;
        logic [BRIGHT_W-1:0] br;
        logic [MASK_W-1:0]   rv;
        logic [MASK_W-1:0]   pv;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset masks: nothing registered, all polarity high
        send_item(ACT_TICK, 3'd0, 8'd0);      // no active channel, counter holds
        send_item(ACT_SET,  3'd3, 8'd6);      // unregistered, dropped
        send_item(ACT_SET,  3'd7, 8'd255);    // forced on still written
        send_item(ACT_SET,  3'd0, 8'd0);      // forced off
        drain();
        apb_write(REG_REGISTERED, 8'hFF);
        apb_write(REG_POLARITY,   8'h0F);

        send_item(ACT_SET,  3'd0, 8'd1);
        send_item(ACT_SET,  3'd1, 8'd14);
        send_item(ACT_SET,  3'd2, 8'd15);     // STEPS-1 counts as fully on
        send_item(ACT_SET,  3'd5, 8'd8);
        send_item(ACT_SET,  3'd3, 8'd9);
        send_item(ACT_TICK, 3'd7, 8'hFF);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_SET,  3'd5, 8'd3);      // channel already held: level replaced
        send_item(ACT_TICK, 3'd2, 8'd0);
        send_item(ACT_SET,  3'd1, 8'd0);      // frees a held channel
        send_item(ACT_SET,  3'd6, 8'd16);
        send_item(ACT_SET,  3'd2, 8'd2);
        send_item(ACT_SET,  3'd4, 8'd7);
        send_item(ACT_SET,  3'd6, 8'd12);
        send_item(ACT_SET,  3'd7, 8'd13);
        send_item(ACT_SET,  3'd1, 8'd4);      // pool now full
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);
        send_item(ACT_TICK, 3'd0, 8'd0);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            drain();
            case (ph)
                0: begin rv = 8'hFF; pv = 8'hFF; end
                1: begin rv = 8'h00; pv = 8'h00; end
                2: begin rv = 8'hFF; pv = 8'h00; end
                default: begin
                    rv = 8'($urandom_range(1, 254));
                    pv = 8'($urandom_range(0, 255));
                end
            endcase
            apb_write(REG_REGISTERED, rv);
            apb_write(REG_POLARITY,   pv);
            tx_calm = (ph == 0);
            rx_calm <= (ph == 0);
            for (int k = 0; k < PER_PHASE; k++) begin
                act = ($urandom_range(0, 1) != 0) ? ACT_TICK : ACT_SET;
                led = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    6:       br = 8'd0;
                    7:       br = 8'(STEPS_DEF - 1);
                    8:       br = 8'hFF;
                    9:       br = 8'($urandom_range(16, 254));
                    default: br = 8'($urandom_range(1, STEPS_DEF - 2));
                endcase
                send_item(act, led, br);
                if (ph == 2 && k == PER_PHASE / 2)
                    drain();
            end
        end

        drain();
        if (fail_count == 0 && writes_pending == 0)
            $display("multi_channel_led_pwm_unit: match");
        else
            $display("multi_channel_led_pwm_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/lpwm_pkg.sv
design/lpwm_cell.sv
design/lpwm_out.sv
design/multi_channel_led_pwm_unit.sv
sim/lpwm_checker.sv
sim/tb_top.sv
